// ===== hw/rtl/gsg_pkg.sv =====
// gsg_pkg: shared types and constants of the gimbal setpoint generator
// holds the item structs, scaling divisors and their reciprocals
// no dependencies
package gsg_pkg;

   // register indexes on the csr port (byte address = 4 * index)
   localparam logic [2:0] REG_START_YAW   = 3'd0;
   localparam logic [2:0] REG_START_PITCH = 3'd1;
   localparam logic [2:0] REG_YAW_TARGET  = 3'd2;
   localparam logic [2:0] REG_PITCH_TGT   = 3'd3;
   localparam logic [2:0] REG_PITCH_LOW   = 3'd4;
   localparam logic [2:0] REG_PITCH_TOP   = 3'd5;
   localparam int         NUM_REGS        = 6;
   localparam int         ADDR_W          = 5;

   // centring step of 0.1 in q16.16
   localparam int STEP_TENTH = 6554;

   // scaled terms: stick_x / 3000, mouse_dx / 300, stick_y / 4000, mouse_dy / 400
   localparam int NUM_TERMS = 4;
   localparam int TERM_SX   = 0;
   localparam int TERM_MX   = 1;
   localparam int TERM_SY   = 2;
   localparam int TERM_MY   = 3;

   localparam int DIV_SX = 3000;
   localparam int DIV_MX = 300;
   localparam int DIV_SY = 4000;
   localparam int DIV_MY = 400;

   localparam logic [11:0] DEN [NUM_TERMS] = '{
      12'(DIV_SX), 12'(DIV_MX), 12'(DIV_SY), 12'(DIV_MY)
   };
   // half divisor, placed in the low 16 bits of the numerator for rounding
   localparam logic [15:0] DEN_HALF [NUM_TERMS] = '{
      16'(DIV_SX / 2), 16'(DIV_MX / 2), 16'(DIV_SY / 2), 16'(DIV_MY / 2)
   };
   // floor(2^32 / divisor)
   localparam logic [23:0] RECIP [NUM_TERMS] = '{
      24'(64'h1_0000_0000 / DIV_SX), 24'(64'h1_0000_0000 / DIV_MX),
      24'(64'h1_0000_0000 / DIV_SY), 24'(64'h1_0000_0000 / DIV_MY)
   };

   // one input item as registered at the entry of the pipeline
   typedef struct packed {
      logic               ctrl_key;
      logic               key_a;
      logic               key_d;
      logic               right_button;
      logic signed [10:0] stick_x;
      logic signed [10:0] stick_y;
      logic signed [15:0] mouse_dx;
      logic signed [15:0] mouse_dy;
      logic signed [31:0] vision_yaw_offset;
      logic signed [31:0] vision_pitch_offset;
      logic signed [31:0] pitch_encoder_angle;
   } item_type;

   // scaled terms and the fields that the state update still needs
   typedef struct packed {
      logic               ctrl_key;
      logic               key_a;
      logic               key_d;
      logic               right_button;
      logic signed [24:0] term_sx;
      logic signed [24:0] term_mx;
      logic signed [24:0] term_sy;
      logic signed [24:0] term_my;
      logic signed [31:0] vision_yaw_offset;
      logic signed [31:0] vision_pitch_offset;
      logic signed [31:0] pitch_encoder_angle;
   } terms_type;

endpackage

// ===== hw/rtl/gimbal_setpoint_generator_top.sv =====
// gimbal_setpoint_generator_top: yaw/pitch setpoint generator with csr registers
// input register, scaling stages (gsg_terms), state update and result register
// depends on gsg_pkg and gsg_terms
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------------
//   req     | req_valid / req_stall   | keys, stick, mouse, vision, encoder angle
//   rsp     | rsp_valid / rsp_stall   | yaw_setpoint, pitch_setpoint, centred
//   csr     | apb, pready tied high   | six 32-bit q16.16 registers at 4*index
//
// an item passes four registers: input register, two scaling stages set by the
// reciprocal multiply and its correction, then the state update that writes the
// result register; one item is accepted every cycle unless a stalled result
// holds the pipeline
// reset clears the pipeline valids, phase, invert flag, yaw and pitch state and csr registers
// a stalled result freezes the whole pipeline, so req_stall follows it
module gimbal_setpoint_generator_top (
   input  logic                         clock,
   input  logic                         reset,
   // item input
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_ctrl_key,
   input  logic                         req_key_a,
   input  logic                         req_key_d,
   input  logic                         req_right_button,
   input  logic signed [10:0]           req_stick_x,
   input  logic signed [10:0]           req_stick_y,
   input  logic signed [15:0]           req_mouse_dx,
   input  logic signed [15:0]           req_mouse_dy,
   input  logic signed [31:0]           req_vision_yaw_offset,
   input  logic signed [31:0]           req_vision_pitch_offset,
   input  logic signed [31:0]           req_pitch_encoder_angle,
   // item output
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [31:0]           rsp_yaw_setpoint,
   output logic signed [31:0]           rsp_pitch_setpoint,
   output logic                         rsp_centred,
   // register port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [gsg_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   typedef enum logic [1:0] {
      PH_UNLOADED,
      PH_CENTRING,
      PH_NORMAL
   } phase_type;

   localparam logic signed [34:0] SAT_MAX = 35'sh0_7FFF_FFFF;
   localparam logic signed [34:0] SAT_MIN = 35'sh7_8000_0000;

   logic signed [31:0] cfg_ff [gsg_pkg::NUM_REGS];
   logic               cfg_wr;
   logic [2:0]         cfg_idx;

   logic               advance;
   logic               v0_ff, v1_ff, v2_ff, rsp_valid_ff;
   gsg_pkg::item_type  item_ff;
   gsg_pkg::terms_type terms;

   phase_type          phase_ff, phase_in;
   logic signed [31:0] yaw_ff, yaw_in, pitch_ff, pitch_in;
   logic               invert_ff, invert_in;
   logic signed [31:0] rsp_yaw_ff, rsp_pitch_ff;
   logic               rsp_centred_ff;

   logic signed [31:0] yaw_cur, pitch_cur, yaw_tgt, pitch_tgt;
   logic               yaw_diff, pitch_diff;
   logic signed [31:0] pitch_step, yaw_step;
   logic               inv_nx;
   logic signed [33:0] yinc, pinc, tm_sel;
   logic signed [31:0] enc, lim_low, lim_top;
   logic               pitch_ok;
   logic signed [31:0] yaw_norm, pitch_norm;

   // integer part, truncated toward zero
   function automatic logic signed [16:0] int_part(input logic signed [31:0] v);
      logic signed [16:0] fl;
      fl = 17'(v >>> 16);
      return fl + 17'((v[31] && (v[15:0] != 16'd0)) ? 1 : 0);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) r = SAT_MAX[31:0];
      else if (v < SAT_MIN) r = SAT_MIN[31:0];
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] step_toward(input logic signed [31:0] cur,
                                                      input logic signed [31:0] tgt);
      logic signed [34:0] s;
      if (cur < tgt) s = 35'(cur) + 35'(gsg_pkg::STEP_TENTH);
      else s = 35'(cur) - 35'(gsg_pkg::STEP_TENTH);
      return sat32(s);
   endfunction

   // register port
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[gsg_pkg::ADDR_W-1:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gsg_pkg::NUM_REGS; i++) cfg_ff[i] <= '0;
      end else if (cfg_wr && (cfg_idx < 3'(gsg_pkg::NUM_REGS))) begin
         cfg_ff[cfg_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      case (cfg_idx)
         gsg_pkg::REG_START_YAW:   csr_prdata = cfg_ff[gsg_pkg::REG_START_YAW];
         gsg_pkg::REG_START_PITCH: csr_prdata = cfg_ff[gsg_pkg::REG_START_PITCH];
         gsg_pkg::REG_YAW_TARGET:  csr_prdata = cfg_ff[gsg_pkg::REG_YAW_TARGET];
         gsg_pkg::REG_PITCH_TGT:   csr_prdata = cfg_ff[gsg_pkg::REG_PITCH_TGT];
         gsg_pkg::REG_PITCH_LOW:   csr_prdata = cfg_ff[gsg_pkg::REG_PITCH_LOW];
         gsg_pkg::REG_PITCH_TOP:   csr_prdata = cfg_ff[gsg_pkg::REG_PITCH_TOP];
         default:                  csr_prdata = '0;
      endcase
   end

   // pipeline moves as one unless the result waits
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v0_ff        <= req_valid;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff.ctrl_key            <= req_ctrl_key;
         item_ff.key_a               <= req_key_a;
         item_ff.key_d               <= req_key_d;
         item_ff.right_button        <= req_right_button;
         item_ff.stick_x             <= req_stick_x;
         item_ff.stick_y             <= req_stick_y;
         item_ff.mouse_dx            <= req_mouse_dx;
         item_ff.mouse_dy            <= req_mouse_dy;
         item_ff.vision_yaw_offset   <= req_vision_yaw_offset;
         item_ff.vision_pitch_offset <= req_vision_pitch_offset;
         item_ff.pitch_encoder_angle <= req_pitch_encoder_angle;
      end
   end

   gsg_terms u_terms (
      .clock   (clock),
      .advance (advance),
      .item    (item_ff),
      .terms   (terms)
   );

   // centring phase: pitch first, then yaw once pitch integer part matches
   always_comb begin
      yaw_cur    = (phase_ff == PH_UNLOADED) ? cfg_ff[gsg_pkg::REG_START_YAW] : yaw_ff;
      pitch_cur  = (phase_ff == PH_UNLOADED) ? cfg_ff[gsg_pkg::REG_START_PITCH] : pitch_ff;
      yaw_tgt    = cfg_ff[gsg_pkg::REG_YAW_TARGET];
      pitch_tgt  = cfg_ff[gsg_pkg::REG_PITCH_TGT];
      yaw_diff   = int_part(yaw_cur) != int_part(yaw_tgt);
      pitch_diff = int_part(pitch_cur) != int_part(pitch_tgt);
      pitch_step = pitch_diff ? step_toward(pitch_cur, pitch_tgt) : pitch_cur;
      yaw_step   = (yaw_diff && (int_part(pitch_step) == int_part(pitch_tgt)))
                   ? step_toward(yaw_cur, yaw_tgt) : yaw_cur;
   end

   // normal mode: invert keys, increments, pitch limit check
   always_comb begin
      if (terms.ctrl_key && terms.key_a) inv_nx = 1'b1;
      else if (terms.ctrl_key && terms.key_d) inv_nx = 1'b0;
      else inv_nx = invert_ff;

      yinc = 34'(terms.term_sx) - 34'(terms.term_mx)
             + (terms.right_button ? 34'(terms.vision_yaw_offset) : 34'sd0);
      tm_sel = inv_nx ? 34'(terms.term_my) : -34'(terms.term_my);
      if (terms.right_button)
         pinc = -34'(terms.term_sy) + tm_sel + 34'(terms.vision_pitch_offset);
      else
         pinc = 34'(terms.term_sy) + 34'(terms.term_my);

      enc      = terms.pitch_encoder_angle;
      lim_low  = cfg_ff[gsg_pkg::REG_PITCH_LOW];
      lim_top  = cfg_ff[gsg_pkg::REG_PITCH_TOP];
      pitch_ok = ((enc <= lim_low) && (pinc > 34'sd0))
              || ((enc >= lim_top) && (pinc < 34'sd0))
              || ((enc > lim_low) && (enc < lim_top));

      yaw_norm   = sat32(35'(yaw_ff) + 35'(yinc));
      pitch_norm = pitch_ok ? sat32(35'(pitch_ff) + 35'(pinc)) : pitch_ff;
   end

   // next state by phase
   always_comb begin
      case (phase_ff)
         PH_NORMAL: begin
            phase_in  = PH_NORMAL;
            yaw_in    = yaw_norm;
            pitch_in  = pitch_norm;
            invert_in = inv_nx;
         end
         default: begin
            phase_in  = (yaw_diff || pitch_diff) ? PH_CENTRING : PH_NORMAL;
            yaw_in    = yaw_step;
            pitch_in  = pitch_step;
            invert_in = invert_ff;
         end
      endcase
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_UNLOADED;
         invert_ff <= 1'b0;
         yaw_ff    <= '0;
         pitch_ff  <= '0;
      end else if (advance && v2_ff) begin
         phase_ff  <= phase_in;
         invert_ff <= invert_in;
         yaw_ff    <= yaw_in;
         pitch_ff  <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && v2_ff) begin
         rsp_yaw_ff     <= yaw_in;
         rsp_pitch_ff   <= pitch_in;
         rsp_centred_ff <= (phase_in == PH_NORMAL);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_yaw_setpoint   = rsp_yaw_ff;
   assign rsp_pitch_setpoint = rsp_pitch_ff;
   assign rsp_centred        = rsp_centred_ff;

   // a result exists only after the first item loaded the start values
   a_loaded_before_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (phase_ff != PH_UNLOADED))
      else $error("result present while phase unloaded");

   // normal mode never falls back
   a_normal_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NORMAL) |=> (phase_ff == PH_NORMAL))
      else $error("left normal mode");

   // a centred result means the state is already in normal mode
   a_centred_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_centred_ff) |-> (phase_ff == PH_NORMAL))
      else $error("centred flag without normal phase");

   // state holds while the result waits
   a_state_frozen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(yaw_ff) && $stable(pitch_ff)
                                       && $stable(invert_ff)))
      else $error("state changed under a stalled result");

endmodule

// ===== hw/rtl/gsg_terms.sv =====
// gsg_terms: two-stage scaling of stick and mouse deltas to q16.16 increments
// rounded division by constants via reciprocal multiply and one correction step
// depends on gsg_pkg
module gsg_terms (
   input  logic               clock,
   input  logic               advance,
   input  gsg_pkg::item_type  item,
   output gsg_pkg::terms_type terms
);

   logic signed [16:0] raw      [gsg_pkg::NUM_TERMS];
   logic               sign_c   [gsg_pkg::NUM_TERMS];
   logic        [31:0] num_c    [gsg_pkg::NUM_TERMS];
   logic        [55:0] prod_c   [gsg_pkg::NUM_TERMS];
   logic               sign_ff  [gsg_pkg::NUM_TERMS];
   logic        [31:0] num_ff   [gsg_pkg::NUM_TERMS];
   logic        [23:0] quot_ff  [gsg_pkg::NUM_TERMS];
   logic        [35:0] back_c   [gsg_pkg::NUM_TERMS];
   logic        [35:0] rem_c    [gsg_pkg::NUM_TERMS];
   logic        [23:0] quot_c   [gsg_pkg::NUM_TERMS];
   logic signed [24:0] term_c   [gsg_pkg::NUM_TERMS];
   gsg_pkg::item_type  pass_ff;

   // magnitude, rounding numerator and reciprocal product
   always_comb begin
      raw[gsg_pkg::TERM_SX] = 17'(item.stick_x);
      raw[gsg_pkg::TERM_MX] = 17'(item.mouse_dx);
      raw[gsg_pkg::TERM_SY] = 17'(item.stick_y);
      raw[gsg_pkg::TERM_MY] = 17'(item.mouse_dy);
      for (int i = 0; i < gsg_pkg::NUM_TERMS; i++) begin
         sign_c[i] = raw[i][16];
         num_c[i]  = {(sign_c[i] ? 16'(-raw[i]) : raw[i][15:0]), gsg_pkg::DEN_HALF[i]};
         prod_c[i] = 56'(num_c[i]) * 56'(gsg_pkg::RECIP[i]);
      end
   end

   // first stage: estimate that is exact or one short
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < gsg_pkg::NUM_TERMS; i++) begin
            sign_ff[i] <= sign_c[i];
            num_ff[i]  <= num_c[i];
            quot_ff[i] <= prod_c[i][55:32];
         end
         pass_ff <= item;
      end
   end

   // correction and sign restore
   always_comb begin
      for (int i = 0; i < gsg_pkg::NUM_TERMS; i++) begin
         back_c[i] = 36'(quot_ff[i]) * 36'(gsg_pkg::DEN[i]);
         rem_c[i]  = 36'(num_ff[i]) - back_c[i];
         quot_c[i] = (rem_c[i] >= 36'(gsg_pkg::DEN[i])) ? quot_ff[i] + 24'd1 : quot_ff[i];
         term_c[i] = sign_ff[i] ? -$signed({1'b0, quot_c[i]}) : $signed({1'b0, quot_c[i]});
      end
   end

   // second stage: signed terms out
   always_ff @(posedge clock) begin
      if (advance) begin
         terms.ctrl_key            <= pass_ff.ctrl_key;
         terms.key_a               <= pass_ff.key_a;
         terms.key_d               <= pass_ff.key_d;
         terms.right_button        <= pass_ff.right_button;
         terms.term_sx             <= term_c[gsg_pkg::TERM_SX];
         terms.term_mx             <= term_c[gsg_pkg::TERM_MX];
         terms.term_sy             <= term_c[gsg_pkg::TERM_SY];
         terms.term_my             <= term_c[gsg_pkg::TERM_MY];
         terms.vision_yaw_offset   <= pass_ff.vision_yaw_offset;
         terms.vision_pitch_offset <= pass_ff.vision_pitch_offset;
         terms.pitch_encoder_angle <= pass_ff.pitch_encoder_angle;
      end
   end

endmodule
